// ===== rtl/pwis_pkg.sv =====
// Package for the PID controller with integral separation.
// Default widths, register map, controller states and command/status types.
// No dependencies.
`default_nettype none

package pwis_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF  = 48;
    localparam int TICK_WIDTH_DEF = 16;

    localparam int THR_WIDTH = 16;
    localparam logic [THR_WIDTH-1:0] THR_DEFAULT = 16'd2560;  // 10.0 in Q8.8

    localparam int PADDR_WIDTH = 5;
    localparam int PDATA_WIDTH = 32;

    typedef enum logic [2:0] {
        REG_KP  = 3'd0,
        REG_KI  = 3'd1,
        REG_KD  = 3'd2,
        REG_THR = 3'd3,
        REG_EN  = 3'd4,
        REG_LO  = 3'd5,
        REG_HI  = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EI_MUL,
        S_INT_UPD,
        S_KP_MUL,
        S_KP_DONE,
        S_KI_MUL,
        S_KI_DONE,
        S_KD_MUL,
        S_KD_DONE,
        S_DIV,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MSTEP,
        OP_INT_UPD,
        OP_KP_DONE,
        OP_KI_DONE,
        OP_KD_DONE,
        OP_DSTEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic mul_last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pwis_in_if.sv =====
// Input channel interface: valid/ready plus set point, measurement and tick.
// Depends on nothing.
`default_nettype none

interface pwis_in_if #(
    parameter int DATA_WIDTH = 16,
    parameter int TICK_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] target_value;
    logic signed [DATA_WIDTH-1:0] measured_value;
    logic        [TICK_WIDTH-1:0] tick_now;

    modport source (output valid, target_value, measured_value, tick_now, input ready);
    modport sink   (input valid, target_value, measured_value, tick_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/pwis_out_if.sv =====
// Output channel interface: valid/ready plus drive value and clamp flag.
// Depends on nothing.
`default_nettype none

interface pwis_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive_value;
    logic                         clamped_flag;

    modport source (output valid, drive_value, clamped_flag, input ready);
    modport sink   (input valid, drive_value, clamped_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/pwis_ctrl.sv =====
// Sequencer for the PID datapath: steps the shared multiplier and divider.
// Depends on pwis_pkg.
`default_nettype none

module pwis_ctrl #(
    parameter int DATA_WIDTH = pwis_pkg::DATA_WIDTH_DEF,
    parameter int TICK_WIDTH = pwis_pkg::TICK_WIDTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output pwis_pkg::dp_cmd_t   cmd,
    input  wire pwis_pkg::dp_stat_t stat
);
    import pwis_pkg::*;

    localparam int MB  = (TICK_WIDTH + 1 > DATA_WIDTH) ? TICK_WIDTH + 1 : DATA_WIDTH;
    localparam int DNW = (2 * DATA_WIDTH + 1 < 64) ? 2 * DATA_WIDTH + 1 : 64;
    localparam int CMAX = (MB > DNW) ? MB : DNW;
    localparam int CNW = $clog2(CMAX);

    state_t           state_reg, state_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic             cnt_zero;

    assign cnt_zero = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EI_MUL;
                    cnt_next   = CNW'(MB - 1);
                end
            end
            S_EI_MUL, S_KP_MUL, S_KI_MUL, S_KD_MUL, S_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    case (state_reg)
                        S_EI_MUL: state_next = S_INT_UPD;
                        S_KP_MUL: state_next = S_KP_DONE;
                        S_KI_MUL: state_next = S_KI_DONE;
                        S_KD_MUL: state_next = S_KD_DONE;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_INT_UPD:
            begin
                state_next = S_KP_MUL;
                cnt_next   = CNW'(MB - 1);
            end
            S_KP_DONE:
            begin
                state_next = S_KI_MUL;
                cnt_next   = CNW'(MB - 1);
            end
            S_KI_DONE:
            begin
                state_next = S_KD_MUL;
                cnt_next   = CNW'(MB - 1);
            end
            S_KD_DONE:
            begin
                state_next = S_DIV;
                cnt_next   = CNW'(DNW - 1);
            end
            S_FINISH:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.mul_last = cnt_zero;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_ACCEPT;
            end
            S_EI_MUL, S_KP_MUL, S_KI_MUL, S_KD_MUL: cmd.op = OP_MSTEP;
            S_INT_UPD: cmd.op = OP_INT_UPD;
            S_KP_DONE: cmd.op = OP_KP_DONE;
            S_KI_DONE: cmd.op = OP_KI_DONE;
            S_KD_DONE: cmd.op = OP_KD_DONE;
            S_DIV:     cmd.op = OP_DSTEP;
            S_FINISH:
            begin
                if (stat.out_free)
                    cmd.op = OP_FINISH;
            end
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pwis_dp.sv =====
// PID datapath: state, shift-add multiplier, restoring divider, output register.
// Depends on pwis_pkg; driven by pwis_ctrl.
`default_nettype none

module pwis_dp #(
    parameter int DATA_WIDTH = pwis_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = pwis_pkg::ACC_WIDTH_DEF,
    parameter int TICK_WIDTH = pwis_pkg::TICK_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire pwis_pkg::dp_cmd_t                cmd,
    output pwis_pkg::dp_stat_t                    stat,
    input  wire signed [DATA_WIDTH-1:0]           target_value,
    input  wire signed [DATA_WIDTH-1:0]           measured_value,
    input  wire        [TICK_WIDTH-1:0]           tick_now,
    input  wire signed [DATA_WIDTH-1:0]           kp,
    input  wire signed [DATA_WIDTH-1:0]           ki,
    input  wire signed [DATA_WIDTH-1:0]           kd,
    input  wire        [pwis_pkg::THR_WIDTH-1:0]  thr,
    input  wire                                   windup_en,
    input  wire signed [DATA_WIDTH-1:0]           lo_lim,
    input  wire signed [DATA_WIDTH-1:0]           hi_lim,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic signed [DATA_WIDTH-1:0]          drive_value,
    output logic                                  clamped_flag
);
    import pwis_pkg::*;

    localparam int EW   = DATA_WIDTH + 1;
    localparam int DEW  = DATA_WIDTH + 2;
    localparam int MB   = (TICK_WIDTH + 1 > DATA_WIDTH) ? TICK_WIDTH + 1 : DATA_WIDTH;
    localparam int AWID = (ACC_WIDTH > DEW) ? ACC_WIDTH : DEW;
    localparam int PW   = AWID + MB;
    localparam int PX   = (PW > 65) ? PW : 65;
    localparam int DNW  = (2 * DATA_WIDTH + 1 < 64) ? 2 * DATA_WIDTH + 1 : 64;
    localparam int CTW  = (EW > THR_WIDTH) ? EW : THR_WIDTH;

    localparam logic signed [PX-1:0] S64_MAX = {{(PX-63){1'b0}}, {63{1'b1}}};
    localparam logic signed [PX-1:0] S64_MIN = {{(PX-63){1'b1}}, {63{1'b0}}};
    localparam logic signed [65:0]   ACC_MAX = {{(67-ACC_WIDTH){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [65:0]   ACC_MIN = {{(67-ACC_WIDTH){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

    // 65-bit sum of two 64-bit values, saturated back to 64 bits
    function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
        logic signed [63:0] r;
        if (s[64] != s[63])
            r = s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        else
            r = s[63:0];
        return r;
    endfunction

    logic signed [EW-1:0]         err_reg, last_err_reg;
    logic        [TICK_WIDTH-1:0] last_tick_reg, elapsed_reg;
    logic signed [DEW-1:0]        derr_reg;
    logic signed [ACC_WIDTH-1:0]  integ_reg;
    logic                         use_i_reg;
    logic signed [PW-1:0]         mc_reg, prod_reg;
    logic        [MB-1:0]         mb_reg;
    logic signed [63:0]           raw_reg;
    logic        [DNW-1:0]        quot_reg;
    logic        [TICK_WIDTH-1:0] rem_reg;
    logic                         dneg_reg;
    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic                         clamp_reg;

    logic signed [EW-1:0]         err_in;
    logic        [TICK_WIDTH-1:0] elapsed_in;
    logic signed [DEW-1:0]        derr_in;
    logic        [EW-1:0]         err_mag;
    logic        [THR_WIDTH-1:0]  thr_eff;
    logic                         use_i_in;
    logic signed [PW-1:0]         addend;
    logic signed [PX-1:0]         prod_x;
    logic signed [63:0]           prod_sat;
    logic signed [65:0]           integ_sum;
    logic signed [ACC_WIDTH-1:0]  integ_clamped;
    logic signed [63:0]           raw_plus_prod;
    logic        [63:0]           div_mag;
    logic        [TICK_WIDTH:0]   div_r2;
    logic                         div_ge;
    logic signed [64:0]           quot_s;
    logic signed [63:0]           dterm;
    logic signed [63:0]           raw_final;
    logic signed [63:0]           hi_s, lo_s;

    assign err_in     = EW'(target_value) - EW'(measured_value);
    assign elapsed_in = tick_now - last_tick_reg;
    assign derr_in    = DEW'(err_in) - DEW'(last_err_reg);
    assign err_mag    = err_in[EW-1] ? (~err_in + 1'b1) : err_in;
    assign thr_eff    = (thr == '0) ? THR_DEFAULT : thr;
    assign use_i_in   = !(windup_en && (CTW'(thr_eff) < CTW'(err_mag)));

    // two's complement multiplier: last bit has negative weight
    assign addend   = cmd.mul_last ? -mc_reg : mc_reg;
    assign prod_x   = PX'(prod_reg);
    assign prod_sat = (prod_x > S64_MAX) ? S64_MAX[63:0] :
                      (prod_x < S64_MIN) ? S64_MIN[63:0] : prod_x[63:0];

    assign integ_sum     = 66'(integ_reg) + 66'(prod_sat);
    assign integ_clamped = (integ_sum > ACC_MAX) ? ACC_MAX[ACC_WIDTH-1:0] :
                           (integ_sum < ACC_MIN) ? ACC_MIN[ACC_WIDTH-1:0] :
                           integ_sum[ACC_WIDTH-1:0];

    assign raw_plus_prod = sat65(65'(raw_reg) + 65'(prod_sat));

    assign div_mag = prod_sat[63] ? (~prod_sat + 1'b1) : prod_sat;
    assign div_r2  = {rem_reg, quot_reg[DNW-1]};
    assign div_ge  = (div_r2 >= {1'b0, elapsed_reg});

    assign quot_s    = 65'($unsigned(quot_reg));
    assign dterm     = (elapsed_reg == '0) ? 64'sd0 :
                       dneg_reg ? 64'(-quot_s) : 64'(quot_s);
    assign raw_final = sat65(65'(raw_reg) + 65'(dterm));
    assign hi_s      = 64'(hi_lim) <<< 8;
    assign lo_s      = 64'(lo_lim) <<< 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            last_tick_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result may replace one that transfers this cycle
            if (cmd.op == OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_ACCEPT:
                begin
                    last_err_reg  <= err_in;
                    last_tick_reg <= tick_now;
                end
                OP_INT_UPD:
                    integ_reg <= integ_clamped;
                default:
                    integ_reg <= integ_reg;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                err_reg     <= err_in;
                elapsed_reg <= elapsed_in;
                derr_reg    <= derr_in;
                use_i_reg   <= use_i_in;
                mc_reg      <= PW'(err_in);
                mb_reg      <= MB'(elapsed_in);
                prod_reg    <= '0;
            end
            OP_MSTEP:
            begin
                if (mb_reg[0])
                    prod_reg <= prod_reg + addend;
                mc_reg <= mc_reg <<< 1;
                mb_reg <= mb_reg >> 1;
            end
            OP_INT_UPD:
            begin
                mc_reg   <= PW'(err_reg);
                mb_reg   <= MB'(kp);
                prod_reg <= '0;
            end
            OP_KP_DONE:
            begin
                raw_reg  <= prod_sat;
                mc_reg   <= PW'(integ_reg);
                mb_reg   <= MB'(ki);
                prod_reg <= '0;
            end
            OP_KI_DONE:
            begin
                if (use_i_reg)
                    raw_reg <= raw_plus_prod;
                mc_reg   <= PW'(derr_reg);
                mb_reg   <= MB'(kd);
                prod_reg <= '0;
            end
            OP_KD_DONE:
            begin
                dneg_reg <= prod_sat[63];
                quot_reg <= div_mag[DNW-1:0];
                rem_reg  <= '0;
            end
            OP_DSTEP:
            begin
                if (div_ge)
                    rem_reg <= TICK_WIDTH'(div_r2 - {1'b0, elapsed_reg});
                else
                    rem_reg <= div_r2[TICK_WIDTH-1:0];
                quot_reg <= {quot_reg[DNW-2:0], div_ge};
            end
            OP_FINISH:
            begin
                if (raw_final > hi_s)
                begin
                    drive_reg <= hi_lim;
                    clamp_reg <= 1'b1;
                end
                else if (raw_final < lo_s)
                begin
                    drive_reg <= lo_lim;
                    clamp_reg <= 1'b1;
                end
                else
                begin
                    drive_reg <= raw_final[DATA_WIDTH+7:8];
                    clamp_reg <= 1'b0;
                end
            end
            default:
                raw_reg <= raw_reg;
        endcase
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign drive_value   = drive_reg;
    assign clamped_flag  = clamp_reg;

endmodule

`default_nettype wire

// ===== rtl/pid_with_integral_separation_top.sv =====
// PID controller with integral-separation anti-windup, signed Q8.8, APB register file.
// One result per input item. Each item passes through MB = max(TICK_WIDTH+1, DATA_WIDTH)
// steps for each of four products on the one shared shift-add multiplier, DNW =
// min(2*DATA_WIDTH+1, 64) steps of the restoring divider for the derivative term, and
// five load and finish steps. The next item is taken only once the result is registered
// and the controller is idle again, so items are not overlapped. A result still waiting
// in the output register only holds the final step of the following item. Registers
// sit at byte address 4*index.
// Depends on pwis_pkg, pwis_in_if, pwis_out_if, pwis_ctrl, pwis_dp.
`default_nettype none

module pid_with_integral_separation_top #(
    parameter int DATA_WIDTH = pwis_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = pwis_pkg::ACC_WIDTH_DEF,
    parameter int TICK_WIDTH = pwis_pkg::TICK_WIDTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    pwis_in_if.sink                              in_ch,
    pwis_out_if.source                           out_ch,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [pwis_pkg::PADDR_WIDTH-1:0]     paddr,
    input  wire  [pwis_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic [pwis_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                 pready
);
    import pwis_pkg::*;

    logic signed [DATA_WIDTH-1:0] kp_reg, ki_reg, kd_reg, lo_reg, hi_reg;
    logic        [THR_WIDTH-1:0]  thr_reg;
    logic                         en_reg;
    logic                         wr_en;
    reg_idx_t                     reg_idx;
    dp_cmd_t                      cmd;
    dp_stat_t                     stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            kd_reg  <= '0;
            thr_reg <= THR_DEFAULT;
            en_reg  <= 1'b0;
            lo_reg  <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            hi_reg  <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KP:  kp_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_KI:  ki_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_KD:  kd_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_THR: thr_reg <= pwdata[THR_WIDTH-1:0];
                REG_EN:  en_reg  <= pwdata[0];
                REG_LO:  lo_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_HI:  hi_reg  <= pwdata[DATA_WIDTH-1:0];
                default: en_reg  <= en_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KP:  prdata = PDATA_WIDTH'($unsigned(kp_reg));
            REG_KI:  prdata = PDATA_WIDTH'($unsigned(ki_reg));
            REG_KD:  prdata = PDATA_WIDTH'($unsigned(kd_reg));
            REG_THR: prdata = PDATA_WIDTH'(thr_reg);
            REG_EN:  prdata = PDATA_WIDTH'(en_reg);
            REG_LO:  prdata = PDATA_WIDTH'($unsigned(lo_reg));
            REG_HI:  prdata = PDATA_WIDTH'($unsigned(hi_reg));
            default: prdata = '0;
        endcase
    end

    pwis_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pwis_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .target_value   (in_ch.target_value),
        .measured_value (in_ch.measured_value),
        .tick_now       (in_ch.tick_now),
        .kp             (kp_reg),
        .ki             (ki_reg),
        .kd             (kd_reg),
        .thr            (thr_reg),
        .windup_en      (en_reg),
        .lo_lim         (lo_reg),
        .hi_lim         (hi_reg),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .drive_value    (out_ch.drive_value),
        .clamped_flag   (out_ch.clamped_flag)
    );

endmodule

`default_nettype wire
